// ===== rtl/flpa_pkg.sv =====
// ----------------------------------------------------------------------------
// flpa_pkg
// Shared types, codes and defaults for the last-packet-per-flow aggregator.
// ----------------------------------------------------------------------------
package flpa_pkg;

    localparam int DEFAULT_ENTRIES     = 64;
    localparam int DEFAULT_HANDLE_BITS = 16;

    localparam int AGG_BITS   = 6;
    localparam int FIELD_HANDLE_BITS = 16;
    localparam int LEN_BITS   = 16;
    localparam int COUNT_BITS = 32;
    localparam int TIME_BITS  = 48;

    typedef enum logic [1:0] {
        ACT_PACKET = 2'd0,
        ACT_NEW    = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    localparam logic PORT_FLUSH     = 1'b0;
    localparam logic PORT_DISPLACED = 1'b1;

    typedef struct packed {
        logic [LEN_BITS-1:0]   length;
        logic [COUNT_BITS-1:0] extra_packets;
        logic [COUNT_BITS-1:0] extra_length;
        logic [TIME_BITS-1:0]  first_time;
    } entry_body_t;

    localparam int BODY_BITS = $bits(entry_body_t);

endpackage

// ===== rtl/flpa_table.sv =====
// ----------------------------------------------------------------------------
// flpa_table
// Synchronous entry memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module flpa_table
    import flpa_pkg::*;
#(
    parameter int DEPTH = DEFAULT_ENTRIES,
    parameter int WIDTH = BODY_BITS + DEFAULT_HANDLE_BITS,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/flpa_fold.sv =====
// ----------------------------------------------------------------------------
// flpa_fold
// Folds a stored entry's counts into an arriving packet with saturation.
// ----------------------------------------------------------------------------
module flpa_fold
    import flpa_pkg::*;
(
    input  entry_body_t           old_body,
    input  logic [COUNT_BITS-1:0] extra_packets_in,
    input  logic [COUNT_BITS-1:0] extra_length_in,
    output logic [COUNT_BITS-1:0] new_extra_packets,
    output logic [COUNT_BITS-1:0] new_extra_length
);

    logic [COUNT_BITS+1:0] packets_sum;
    logic [COUNT_BITS+1:0] length_sum;

    assign packets_sum = (COUNT_BITS+2)'(extra_packets_in)
                       + (COUNT_BITS+2)'(1)
                       + (COUNT_BITS+2)'(old_body.extra_packets);

    assign length_sum = (COUNT_BITS+2)'(extra_length_in)
                      + (COUNT_BITS+2)'(old_body.length)
                      + (COUNT_BITS+2)'(old_body.extra_length);

    assign new_extra_packets = (|packets_sum[COUNT_BITS+1:COUNT_BITS])
                             ? '1 : packets_sum[COUNT_BITS-1:0];
    assign new_extra_length  = (|length_sum[COUNT_BITS+1:COUNT_BITS])
                             ? '1 : length_sum[COUNT_BITS-1:0];

endmodule

// ===== rtl/flow_last_packet_aggregator_top.sv =====
// ----------------------------------------------------------------------------
// flow_last_packet_aggregator_top
// Per-flow last-packet table with count folding, delete and clear flush.
// ----------------------------------------------------------------------------
// A command is transferred when start is high and busy is low. A packet or a
// delete reads its table entry in the accept cycle and finishes in the next
// one; its result, if any, appears on the cycle after that, marked by
// out_valid for exactly one cycle.
// A clear walks the table in index order after the accept cycle. An empty
// entry takes only the scan state; a valid one takes the scan state and then
// the output state. The walk stops after the last valid entry, and each valid
// entry gives one result.
// The last result of every command carries last_of_run; the last one of a
// clear also carries stop_request when stop_on_clear is set.
// The receiver cannot stall: out_valid marks a transfer that always completes.
// stop_on_clear is written through cfg_valid/cfg_ready, with cfg_ready always
// high; the user must do so only while the block is idle; it is not enforced.
// Reset clears every valid bit and the configuration register at once; the
// block accepts a command on the first cycle after reset.
// ----------------------------------------------------------------------------
module flow_last_packet_aggregator_top
    import flpa_pkg::*;
#(
    parameter int ENTRIES     = DEFAULT_ENTRIES,
    parameter int HANDLE_BITS = DEFAULT_HANDLE_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   action,
    input  logic [AGG_BITS-1:0]          aggregate,
    input  logic [FIELD_HANDLE_BITS-1:0] packet_handle,
    input  logic [LEN_BITS-1:0]          packet_length,
    input  logic [COUNT_BITS-1:0]        extra_packets_in,
    input  logic [COUNT_BITS-1:0]        extra_length_in,
    input  logic [TIME_BITS-1:0]         arrival_time,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_data,
    output logic                         out_valid,
    output logic                         port,
    output logic [FIELD_HANDLE_BITS-1:0] out_handle,
    output logic [LEN_BITS-1:0]          out_length,
    output logic [COUNT_BITS-1:0]        out_extra_packets,
    output logic [COUNT_BITS-1:0]        out_extra_length,
    output logic [TIME_BITS-1:0]         out_first_time,
    output logic                         last_of_run,
    output logic                         stop_request
);

    localparam int AW       = $clog2(ENTRIES);
    localparam int REC_BITS = HANDLE_BITS + BODY_BITS;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_EXEC     = 4'b0010,
        ST_CLR_SCAN = 4'b0100,
        ST_CLR_OUT  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic                 stop_cfg_reg, stop_cfg_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 port_reg, port_next;
    logic                 last_reg, last_next;
    logic                 stop_reg, stop_next;

    action_t               action_reg;
    logic [AW-1:0]         agg_reg;
    logic [31:0]           handle_wide_reg;
    logic [LEN_BITS-1:0]   length_reg;
    logic [COUNT_BITS-1:0] xp_reg;
    logic [COUNT_BITS-1:0] xl_reg;
    logic [TIME_BITS-1:0]  time_reg;

    logic [FIELD_HANDLE_BITS-1:0] out_handle_reg;
    entry_body_t                  out_body_reg;

    logic                  accept;
    logic                  in_range;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [REC_BITS-1:0]   rd_data;
    logic                  wr_en;
    logic [REC_BITS-1:0]   wr_data;
    entry_body_t           rd_body;
    logic [HANDLE_BITS-1:0] rd_handle;
    logic [31:0]           rd_handle_wide;
    entry_body_t           new_body;
    logic                  hit;
    logic [COUNT_BITS-1:0] fold_packets;
    logic [COUNT_BITS-1:0] fold_length;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign in_range  = ({1'b0, aggregate} < (AGG_BITS+1)'(ENTRIES));

    assign rd_body        = rd_data[BODY_BITS-1:0];
    assign rd_handle      = rd_data[REC_BITS-1:BODY_BITS];
    assign rd_handle_wide = 32'(rd_handle);
    assign hit            = valid_reg[agg_reg];

    flpa_table #(
        .DEPTH (ENTRIES),
        .WIDTH (REC_BITS)
    ) u_table (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (agg_reg),
        .wr_data (wr_data)
    );

    flpa_fold u_fold (
        .old_body          (rd_body),
        .extra_packets_in  (xp_reg),
        .extra_length_in   (xl_reg),
        .new_extra_packets (fold_packets),
        .new_extra_length  (fold_length)
    );

    always_comb
    begin
        new_body.length        = length_reg;
        new_body.extra_packets = hit ? fold_packets : xp_reg;
        new_body.extra_length  = hit ? fold_length : xl_reg;
        new_body.first_time    = hit ? rd_body.first_time : time_reg;
        wr_data = {handle_wide_reg[HANDLE_BITS-1:0], new_body};
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        valid_next     = valid_reg;
        stop_cfg_next  = stop_cfg_reg;
        out_valid_next = 1'b0;
        port_next      = PORT_FLUSH;
        last_next      = 1'b0;
        stop_next      = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        wr_en          = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            stop_cfg_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = aggregate[AW-1:0];
                if (start)
                begin
                    if (action == ACT_CLEAR)
                    begin
                        idx_next   = '0;
                        state_next = ST_CLR_SCAN;
                    end
                    else if (in_range && (action inside {ACT_PACKET, ACT_DELETE}))
                    begin
                        rd_en      = 1'b1;
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                if (action_reg == ACT_PACKET)
                begin
                    wr_en               = 1'b1;
                    valid_next[agg_reg] = 1'b1;
                    if (hit)
                    begin
                        out_valid_next = 1'b1;
                        port_next      = PORT_DISPLACED;
                        last_next      = 1'b1;
                    end
                end
                else if (hit)
                begin
                    valid_next[agg_reg] = 1'b0;
                    out_valid_next      = 1'b1;
                    port_next           = PORT_FLUSH;
                    last_next           = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_CLR_SCAN:
            begin
                if (valid_reg[idx_reg])
                begin
                    rd_en               = 1'b1;
                    valid_next[idx_reg] = 1'b0;
                    state_next          = ST_CLR_OUT;
                end
                else if (idx_reg == AW'(ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_CLR_OUT:
            begin
                out_valid_next = 1'b1;
                port_next      = PORT_FLUSH;
                last_next      = ~|valid_reg;
                stop_next      = last_next && stop_cfg_reg;
                if (last_next)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_CLR_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            valid_reg     <= '0;
            stop_cfg_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            port_reg      <= PORT_FLUSH;
            last_reg      <= 1'b0;
            stop_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            valid_reg     <= valid_next;
            stop_cfg_reg  <= stop_cfg_next;
            out_valid_reg <= out_valid_next;
            port_reg      <= port_next;
            last_reg      <= last_next;
            stop_reg      <= stop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg      <= action_t'(action);
            agg_reg         <= aggregate[AW-1:0];
            handle_wide_reg <= 32'(packet_handle);
            length_reg      <= packet_length;
            xp_reg          <= extra_packets_in;
            xl_reg          <= extra_length_in;
            time_reg        <= arrival_time;
        end
        if (out_valid_next)
        begin
            out_handle_reg <= rd_handle_wide[FIELD_HANDLE_BITS-1:0];
            out_body_reg   <= rd_body;
        end
    end

    assign out_valid         = out_valid_reg;
    assign port              = port_reg;
    assign out_handle        = out_handle_reg;
    assign out_length        = out_body_reg.length;
    assign out_extra_packets = out_body_reg.extra_packets;
    assign out_extra_length  = out_body_reg.extra_length;
    assign out_first_time    = out_body_reg.first_time;
    assign last_of_run       = last_reg;
    assign stop_request      = stop_reg;

`ifndef SYNTHESIS
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($past(state_reg) == ST_EXEC || $past(state_reg) == ST_CLR_OUT))
        else $error("Result raised outside an execute or flush cycle.");

    a_stop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |-> (out_valid_reg && last_reg && port_reg == PORT_FLUSH))
        else $error("Stop request without the final flush result.");

    a_flush_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> busy)
        else $error("Block went idle in the middle of a flush.");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action == ACT_CLEAR) |=> (state_reg == ST_CLR_SCAN))
        else $error("Clear command did not start the table walk.");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the last-packet-per-flow aggregator.
// ----------------------------------------------------------------------------
// Commands go in through the start/busy handshake with random gaps. A table
// model in the testbench folds each packet into its flow entry and predicts
// the displaced, deleted and flushed entries. A checker compares every
// strobed result with the oldest prediction. Directed tests cover field
// extremes, counter saturation, delete and clear corner cases and both
// settings of the stop_on_clear flag. Random traffic on a few busy flows follows.
// ----------------------------------------------------------------------------
module tb;

    import flpa_pkg::*;

    localparam int NUM_FLOWS     = DEFAULT_ENTRIES;
    localparam int SETTLE_CYCLES = 2 * NUM_FLOWS + 8;

    typedef struct packed {
        action_t                      op;
        logic [AGG_BITS-1:0]          flow;
        logic [FIELD_HANDLE_BITS-1:0] handle;
        logic [LEN_BITS-1:0]          length;
        logic [COUNT_BITS-1:0]        extra_packets;
        logic [COUNT_BITS-1:0]        extra_length;
        logic [TIME_BITS-1:0]         stamp;
    } item_t;

    typedef struct packed {
        logic                         port;
        logic [FIELD_HANDLE_BITS-1:0] handle;
        logic [LEN_BITS-1:0]          length;
        logic [COUNT_BITS-1:0]        extra_packets;
        logic [COUNT_BITS-1:0]        extra_length;
        logic [TIME_BITS-1:0]         first_time;
        logic                         last;
        logic                         stop;
    } emit_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [1:0]                   action;
    logic [AGG_BITS-1:0]          aggregate;
    logic [FIELD_HANDLE_BITS-1:0] packet_handle;
    logic [LEN_BITS-1:0]          packet_length;
    logic [COUNT_BITS-1:0]        extra_packets_in;
    logic [COUNT_BITS-1:0]        extra_length_in;
    logic [TIME_BITS-1:0]         arrival_time;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic                         cfg_data;
    logic                         out_valid;
    logic                         port;
    logic [FIELD_HANDLE_BITS-1:0] out_handle;
    logic [LEN_BITS-1:0]          out_length;
    logic [COUNT_BITS-1:0]        out_extra_packets;
    logic [COUNT_BITS-1:0]        out_extra_length;
    logic [TIME_BITS-1:0]         out_first_time;
    logic                         last_of_run;
    logic                         stop_request;

    logic                         flow_valid [NUM_FLOWS];
    logic [FIELD_HANDLE_BITS-1:0] flow_handle [NUM_FLOWS];
    logic [LEN_BITS-1:0]          flow_length [NUM_FLOWS];
    logic [COUNT_BITS-1:0]        flow_extra_packets [NUM_FLOWS];
    logic [COUNT_BITS-1:0]        flow_extra_length [NUM_FLOWS];
    logic [TIME_BITS-1:0]         flow_first_time [NUM_FLOWS];
    logic                         stop_on_flush;

    emit_t pending_emits [$];
    int    mismatch_count;

    flow_last_packet_aggregator_top i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .action            (action),
        .aggregate         (aggregate),
        .packet_handle     (packet_handle),
        .packet_length     (packet_length),
        .extra_packets_in  (extra_packets_in),
        .extra_length_in   (extra_length_in),
        .arrival_time      (arrival_time),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .out_valid         (out_valid),
        .port              (port),
        .out_handle        (out_handle),
        .out_length        (out_length),
        .out_extra_packets (out_extra_packets),
        .out_extra_length  (out_extra_length),
        .out_first_time    (out_first_time),
        .last_of_run       (last_of_run),
        .stop_request      (stop_request)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("Verification failed");
        $finish;
    end

    function automatic logic [COUNT_BITS-1:0] saturating_sum(logic [COUNT_BITS-1:0] a,
                                                             logic [COUNT_BITS-1:0] b,
                                                             logic [COUNT_BITS-1:0] c);
        logic [COUNT_BITS+1:0] total;
        total = a + b + c;
        if (total > {2'b00, {COUNT_BITS{1'b1}}})
            return '1;
        return total[COUNT_BITS-1:0];
    endfunction

    function automatic emit_t stored_entry(int slot, logic which_port, logic last, logic stop);
        emit_t e;
        e.port          = which_port;
        e.handle        = flow_handle[slot];
        e.length        = flow_length[slot];
        e.extra_packets = flow_extra_packets[slot];
        e.extra_length  = flow_extra_length[slot];
        e.first_time    = flow_first_time[slot];
        e.last          = last;
        e.stop          = stop;
        return e;
    endfunction

    function automatic void fold_into_flow_table(item_t it);
        int                    last_slot;
        logic [COUNT_BITS-1:0] packets;
        logic [COUNT_BITS-1:0] bytes;
        logic [TIME_BITS-1:0]  first;
        last_slot = -1;
        case (it.op)
            ACT_CLEAR:
            begin
                for (int i = 0; i < NUM_FLOWS; i++)
                    if (flow_valid[i])
                        last_slot = i;
                for (int i = 0; i < NUM_FLOWS; i++)
                begin
                    if (flow_valid[i])
                    begin
                        pending_emits.push_back(stored_entry(i, PORT_FLUSH, i == last_slot,
                                                             i == last_slot && stop_on_flush));
                        flow_valid[i] = 1'b0;
                    end
                end
            end
            ACT_DELETE:
            begin
                if (flow_valid[it.flow])
                begin
                    pending_emits.push_back(stored_entry(it.flow, PORT_FLUSH, 1'b1, 1'b0));
                    flow_valid[it.flow] = 1'b0;
                end
            end
            ACT_PACKET:
            begin
                packets = it.extra_packets;
                bytes   = it.extra_length;
                first   = it.stamp;
                if (flow_valid[it.flow])
                begin
                    packets = saturating_sum(it.extra_packets, COUNT_BITS'(1),
                                             flow_extra_packets[it.flow]);
                    bytes   = saturating_sum(it.extra_length, COUNT_BITS'(flow_length[it.flow]),
                                             flow_extra_length[it.flow]);
                    first   = flow_first_time[it.flow];
                    pending_emits.push_back(stored_entry(it.flow, PORT_DISPLACED, 1'b1, 1'b0));
                end
                flow_valid[it.flow]         = 1'b1;
                flow_handle[it.flow]        = it.handle;
                flow_length[it.flow]        = it.length;
                flow_extra_packets[it.flow] = packets;
                flow_extra_length[it.flow]  = bytes;
                flow_first_time[it.flow]    = first;
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, emit_t want, emit_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t: %s", $realtime, what);
            $display("  expected port=%0d handle=%h len=%h xp=%h xl=%h first=%h last=%0d stop=%0d",
                     want.port, want.handle, want.length, want.extra_packets,
                     want.extra_length, want.first_time, want.last, want.stop);
            $display("  actual   port=%0d handle=%h len=%h xp=%h xl=%h first=%h last=%0d stop=%0d",
                     got.port, got.handle, got.length, got.extra_packets,
                     got.extra_length, got.first_time, got.last, got.stop);
        end
    endtask

    always @(posedge clk)
    begin : check_emits
        emit_t got;
        emit_t want;
        if (rst_n && out_valid)
        begin
            got.port          = port;
            got.handle        = out_handle;
            got.length        = out_length;
            got.extra_packets = out_extra_packets;
            got.extra_length  = out_extra_length;
            got.first_time    = out_first_time;
            got.last          = last_of_run;
            got.stop          = stop_request;
            if (pending_emits.size() == 0)
                report_mismatch("result with no expected entry", '0, got);
            else
            begin
                want = pending_emits.pop_front();
                if (got !== want)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(item_t it, int gap);
        action           <= it.op;
        aggregate        <= it.flow;
        packet_handle    <= it.handle;
        packet_length    <= it.length;
        extra_packets_in <= it.extra_packets;
        extra_length_in  <= it.extra_length;
        arrival_time     <= it.stamp;
        start            <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        fold_into_flow_table(it);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_quiet();
        start <= 1'b0;
        while (pending_emits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_stop_flag(logic value);
        wait_for_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        stop_on_flush = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic item_t packet_item(int flow, logic [FIELD_HANDLE_BITS-1:0] handle,
                                          logic [LEN_BITS-1:0] length,
                                          logic [COUNT_BITS-1:0] xp,
                                          logic [COUNT_BITS-1:0] xl,
                                          logic [TIME_BITS-1:0] stamp);
        item_t it;
        it.op            = ACT_PACKET;
        it.flow          = AGG_BITS'(flow);
        it.handle        = handle;
        it.length        = length;
        it.extra_packets = xp;
        it.extra_length  = xl;
        it.stamp         = stamp;
        return it;
    endfunction

    function automatic item_t command_item(action_t op, int flow);
        item_t it;
        it = packet_item(flow, FIELD_HANDLE_BITS'($urandom), LEN_BITS'($urandom),
                         $urandom, $urandom, TIME_BITS'({$urandom, $urandom}));
        it.op = op;
        return it;
    endfunction

    function automatic logic [COUNT_BITS-1:0] random_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom_range(0, 15);
        if (r < 8)
            return $urandom;
        return {COUNT_BITS{1'b1}} - $urandom_range(0, 15);
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    r;
        int    flow;
        r = $urandom_range(0, 7);
        if ($urandom_range(0, 3) != 0)
            flow = (r < 4) ? r : NUM_FLOWS - 8 + r;
        else
            flow = $urandom_range(0, NUM_FLOWS - 1);
        r = $urandom_range(0, 99);
        if (r < 70)
            it = packet_item(flow, FIELD_HANDLE_BITS'($urandom), LEN_BITS'($urandom),
                             random_count(), random_count(),
                             TIME_BITS'({$urandom, $urandom}));
        else if (r < 78)
            it = command_item(ACT_NEW, flow);
        else if (r < 93)
            it = command_item(ACT_DELETE, flow);
        else
            it = command_item(ACT_CLEAR, flow);
        return it;
    endfunction

    task automatic test_fold_and_saturate();
        send_item(packet_item(0, 16'h0000, 16'h0000, 32'h0, 32'h0, 48'h0), pick_gap());
        send_item(packet_item(0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              48'hFFFF_FFFF_FFFF), pick_gap());
        send_item(packet_item(0, 16'h1234, 16'h0040, 32'h3, 32'h100, 48'h1000), pick_gap());
        send_item(packet_item(63, 16'h5555, 16'hAAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                              48'hAAAA_5555_AAAA), pick_gap());
        send_item(packet_item(63, 16'hAAAA, 16'h5555, 32'h5555_5555, 32'hAAAA_AAAA,
                              48'h5555_AAAA_5555), pick_gap());
        send_item(packet_item(63, 16'h00FF, 16'hFF00, 32'h0, 32'h0, 48'h0000_FFFF_0000),
                  pick_gap());
        send_item(packet_item(42, 16'hFF00, 16'h00FF, 32'h7, 32'h9, 48'h1), pick_gap());
        send_item(packet_item(21, 16'h0F0F, 16'hF0F0, 32'h1, 32'h2, 48'h2), pick_gap());
        send_item(packet_item(21, 16'hF0F0, 16'h0F0F, 32'h0, 32'h0, 48'h3), pick_gap());
    endtask

    task automatic test_delete_and_new();
        send_item(command_item(ACT_NEW, 0), pick_gap());
        send_item(command_item(ACT_DELETE, 0), pick_gap());
        send_item(command_item(ACT_DELETE, 0), pick_gap());
        send_item(packet_item(0, 16'hBEEF, 16'h0400, 32'h0, 32'h0, 48'h10), pick_gap());
        send_item(command_item(ACT_NEW, 5), pick_gap());
        send_item(command_item(ACT_DELETE, 21), pick_gap());
        wait_for_quiet();
    endtask

    task automatic test_clear_flush();
        write_stop_flag(1'b0);
        send_item(command_item(ACT_CLEAR, 0), pick_gap());
        send_item(command_item(ACT_CLEAR, 63), pick_gap());
        send_item(packet_item(1, 16'h0001, 16'h0010, 32'h0, 32'h0, 48'h20), pick_gap());
        send_item(packet_item(2, 16'h0002, 16'h0020, 32'h1, 32'h1, 48'h21), pick_gap());
        send_item(packet_item(62, 16'h003E, 16'h0030, 32'h2, 32'h2, 48'h22), pick_gap());
        send_item(packet_item(62, 16'h013E, 16'h0031, 32'h3, 32'h3, 48'h23), pick_gap());
        write_stop_flag(1'b1);
        send_item(command_item(ACT_CLEAR, 7), pick_gap());
        send_item(command_item(ACT_CLEAR, 7), pick_gap());
    endtask

    task automatic test_random_traffic(logic stop_flag, int count);
        write_stop_flag(stop_flag);
        for (int i = 0; i < count; i++)
        begin
            if (i % 75 == 74)
                wait_for_quiet();
            send_item(random_item(), (i % 64 < 16) ? 0 : pick_gap());
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        start            <= 1'b0;
        action           <= ACT_NEW;
        aggregate        <= '0;
        packet_handle    <= '0;
        packet_length    <= '0;
        extra_packets_in <= '0;
        extra_length_in  <= '0;
        arrival_time     <= '0;
        cfg_valid        <= 1'b0;
        cfg_data         <= 1'b0;
        mismatch_count = 0;
        stop_on_flush  = 1'b0;
        for (int i = 0; i < NUM_FLOWS; i++)
            flow_valid[i] = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fold_and_saturate();
        test_delete_and_new();
        test_clear_flush();
        test_random_traffic(1'b0, 225);
        test_random_traffic(1'b1, 225);

        wait_for_quiet();
        if (mismatch_count == 0 && pending_emits.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
